@@ rtl/core/trilinear_interpolator_assert.svh @@
// Assertion macros used by the trilinear interpolator RTL.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef TRILINEAR_INTERPOLATOR_ASSERT_SVH
`define TRILINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("trilinear interpolator check failed");
`define TI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trilinear interpolator sequence check failed");
`else
`define TI_ASSERT(label, clk, rst_n, prop)
`define TI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ti_pkg.sv @@
// Shared types, widths and helpers of the trilinear interpolator.
// Used by ti_ctrl, ti_dp and trilinear_interpolator; depends on nothing.
`default_nettype none
package ti_pkg;
	localparam int LIMB_W = 32;
	localparam int LIMBS  = 4;
	localparam int PROD_W = LIMB_W * LIMBS;
	localparam int VOL_W  = 96;
	localparam int ACC_W  = 131;
	localparam int BIT_W  = 8;

	typedef struct packed {
		logic [4:0]  pad;
		logic [31:0] z_point;
		logic [31:0] z_high;
		logic [31:0] z_low;
		logic [31:0] y_point;
		logic [31:0] y_high;
		logic [31:0] y_low;
		logic [31:0] x_point;
		logic [31:0] x_high;
		logic [31:0] x_low;
		logic [31:0] corner_value;
		logic [2:0]  corner_index;
	} in_t;

	typedef enum logic [2:0] {MS_VY, MS_VZ, MS_M2, MS_M3, MS_MV} msel_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CAPTURE, OP_VOL_INIT, OP_MUL, OP_VOL_SAVE,
		OP_TERM_INIT, OP_ACC, OP_DIV_INIT, OP_DIV, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       wr_corner;
		msel_t      msel;
		logic [1:0] limb;
		logic [2:0] corner;
	} cmd_t;

	typedef struct packed {
		logic degen;
	} status_t;

	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} span_t;

	function automatic span_t span(input logic [31:0] hi, input logic [31:0] lo);
		logic [32:0] d;
		logic [32:0] n;
		span_t s;
		d = {hi[31], hi} - {lo[31], lo};
		n = 33'd0 - d;
		s.neg = d[32];
		s.mag = d[32] ? n[31:0] : d[31:0];
		return s;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/trilinear_interpolator.sv @@
// Trilinear interpolator top level: stream ports, sequencer and datapath.
// A load transfer (tuser 0) stores one corner sample. A compute transfer (tuser 1)
// runs two volume products and eight corner products limb by limb through one 32x32
// multiplier, and a restoring divider then yields one quotient bit per cycle over 131
// bits. A cell with a zero span skips these and goes straight to the output. A
// held-off output stalls the result. A new transfer is taken while the last result
// waits on the output. Every corner must be loaded before a compute.
// Depends on ti_pkg, ti_ctrl and ti_dp.
`default_nettype none
module trilinear_interpolator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// corner_index, corner_value, x_low, x_high, x_point, y_low, y_high,
	// y_point, z_low, z_high, z_point, zero fill
	input  wire logic [327:0] s_axis_tdata,
	// cmd
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// interpolated
	output logic [31:0]       m_axis_tdata,
	// degenerate, saturated
	output logic [1:0]        m_axis_tuser
);
	ti_pkg::cmd_t    cmd;
	ti_pkg::status_t status;

	ti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	ti_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);
endmodule
`default_nettype wire

@@ rtl/core/ti_dp.sv @@
// Datapath of the trilinear interpolator: corner store, limb multiplier,
// accumulator, restoring divider and result register. Depends on ti_pkg.
`default_nettype none
module ti_dp (
	input  wire logic              clk,
	input  wire ti_pkg::cmd_t      cmd,
	output ti_pkg::status_t        status,
	input  wire logic [327:0]      in_data,
	output logic [31:0]            out_data,
	output logic [1:0]             out_user
);
	ti_pkg::in_t in_s;
	logic [31:0] store_q [8];
	logic [31:0] xl_q, xh_q, xp_q, yl_q, yh_q, yp_q, zl_q, zh_q, zp_q;
	logic [ti_pkg::PROD_W-1:0] p_q;
	logic [31:0] carry_q;
	logic [ti_pkg::VOL_W-1:0] vol_q;
	logic [ti_pkg::ACC_W-1:0] acc_q, nq_q;
	logic [ti_pkg::VOL_W-1:0] rem_q;
	logic neg_q;
	ti_pkg::span_t sx, sy, sz, s1, s2, s3;
	logic [31:0] v, mv, mop, plimb;
	logic [63:0] t;
	logic term_neg, res_neg, high, sat;
	logic [ti_pkg::ACC_W-1:0] nacc;
	logic [ti_pkg::VOL_W:0] rsh;
	logic ge;
	logic [31:0] lim, magf;

	assign in_s = ti_pkg::in_t'(in_data);
	assign sx = ti_pkg::span(xh_q, xl_q);
	assign sy = ti_pkg::span(yh_q, yl_q);
	assign sz = ti_pkg::span(zh_q, zl_q);
	assign status.degen = (sx.mag == 32'd0) || (sy.mag == 32'd0) || (sz.mag == 32'd0);
	assign s1 = cmd.corner[1] ? ti_pkg::span(xp_q, xl_q) : ti_pkg::span(xh_q, xp_q);
	assign s2 = cmd.corner[0] ? ti_pkg::span(yp_q, yl_q) : ti_pkg::span(yh_q, yp_q);
	assign s3 = cmd.corner[2] ? ti_pkg::span(zh_q, zp_q) : ti_pkg::span(zp_q, zl_q);
	assign v = store_q[cmd.corner];
	assign mv = v[31] ? 32'd0 - v : v;
	assign term_neg = s1.neg ^ s2.neg ^ s3.neg ^ v[31];

	always_comb begin
		unique case (cmd.msel)
			ti_pkg::MS_VY: mop = sy.mag;
			ti_pkg::MS_VZ: mop = sz.mag;
			ti_pkg::MS_M2: mop = s2.mag;
			ti_pkg::MS_M3: mop = s3.mag;
			ti_pkg::MS_MV: mop = mv;
			default:       mop = 32'd0;
		endcase
	end

	assign plimb = p_q[cmd.limb*ti_pkg::LIMB_W +: ti_pkg::LIMB_W];
	assign t = 64'(plimb) * 64'(mop) + ((cmd.limb == 2'd0) ? 64'd0 : 64'(carry_q));
	assign nacc = ti_pkg::ACC_W'(0) - acc_q;
	assign rsh = {rem_q, nq_q[ti_pkg::ACC_W-1]};
	assign ge = rsh >= {1'b0, vol_q};
	assign res_neg = neg_q ^ sx.neg ^ sy.neg ^ sz.neg;
	assign high = |nq_q[ti_pkg::ACC_W-1:32];
	assign lim = res_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign sat = high || (nq_q[31:0] > lim);
	assign magf = sat ? lim : nq_q[31:0];

	always_ff @(posedge clk) begin
		if (cmd.wr_corner) begin
			store_q[in_s.corner_index] <= in_s.corner_value;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ti_pkg::OP_CAPTURE: begin
				xl_q <= in_s.x_low;  xh_q <= in_s.x_high; xp_q <= in_s.x_point;
				yl_q <= in_s.y_low;  yh_q <= in_s.y_high; yp_q <= in_s.y_point;
				zl_q <= in_s.z_low;  zh_q <= in_s.z_high; zp_q <= in_s.z_point;
			end
			ti_pkg::OP_VOL_INIT: begin
				p_q <= ti_pkg::PROD_W'(sx.mag);
				acc_q <= '0;
			end
			ti_pkg::OP_MUL: begin
				p_q[cmd.limb*ti_pkg::LIMB_W +: ti_pkg::LIMB_W] <= t[31:0];
				carry_q <= t[63:32];
			end
			ti_pkg::OP_VOL_SAVE: vol_q <= p_q[ti_pkg::VOL_W-1:0];
			ti_pkg::OP_TERM_INIT: p_q <= ti_pkg::PROD_W'(s1.mag);
			ti_pkg::OP_ACC: begin
				if (term_neg) begin
					acc_q <= acc_q - ti_pkg::ACC_W'(p_q);
				end else begin
					acc_q <= acc_q + ti_pkg::ACC_W'(p_q);
				end
			end
			ti_pkg::OP_DIV_INIT: begin
				neg_q <= acc_q[ti_pkg::ACC_W-1];
				nq_q <= acc_q[ti_pkg::ACC_W-1] ? nacc : acc_q;
				rem_q <= '0;
			end
			ti_pkg::OP_DIV: begin
				rem_q <= ge ? ti_pkg::VOL_W'(rsh - {1'b0, vol_q}) : rsh[ti_pkg::VOL_W-1:0];
				nq_q <= {nq_q[ti_pkg::ACC_W-2:0], ge};
			end
			ti_pkg::OP_OUT: begin
				if (status.degen) begin
					out_data <= 32'd0;
					out_user <= 2'b01;
				end else begin
					out_data <= res_neg ? 32'd0 - magf : magf;
					out_user <= {sat, 1'b0};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/core/ti_ctrl.sv @@
// Sequencer of the trilinear interpolator: handshakes and datapath commands.
// Depends on ti_pkg and trilinear_interpolator_assert.svh.
`default_nettype none
`include "trilinear_interpolator_assert.svh"
module ti_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_cmd,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ti_pkg::cmd_t         cmd,
	input  wire ti_pkg::status_t status
);
	typedef enum logic [3:0] {
		S_IDLE, S_VOL, S_VMUL, S_VSAVE, S_TINIT, S_TMUL, S_TACC, S_DINIT, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] limb_q, step_q;
	logic [2:0] corner_q;
	logic [ti_pkg::BIT_W-1:0] bit_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		cmd.op = ti_pkg::OP_NONE;
		cmd.msel = ti_pkg::MS_VY;
		cmd.limb = limb_q;
		cmd.corner = corner_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = ti_pkg::OP_CAPTURE;
					cmd.wr_corner = !in_cmd;
				end
			end
			S_VOL:   cmd.op = status.degen ? ti_pkg::OP_NONE : ti_pkg::OP_VOL_INIT;
			S_VMUL: begin
				cmd.op = ti_pkg::OP_MUL;
				cmd.msel = (step_q == 2'd0) ? ti_pkg::MS_VY : ti_pkg::MS_VZ;
			end
			S_VSAVE: cmd.op = ti_pkg::OP_VOL_SAVE;
			S_TINIT: cmd.op = ti_pkg::OP_TERM_INIT;
			S_TMUL: begin
				cmd.op = ti_pkg::OP_MUL;
				unique case (step_q)
					2'd0:    cmd.msel = ti_pkg::MS_M2;
					2'd1:    cmd.msel = ti_pkg::MS_M3;
					default: cmd.msel = ti_pkg::MS_MV;
				endcase
			end
			S_TACC:  cmd.op = ti_pkg::OP_ACC;
			S_DINIT: cmd.op = ti_pkg::OP_DIV_INIT;
			S_DIV:   cmd.op = ti_pkg::OP_DIV;
			S_OUT:   cmd.op = out_free ? ti_pkg::OP_OUT : ti_pkg::OP_NONE;
			default: cmd.op = ti_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limb_q <= '0;
			step_q <= '0;
			corner_q <= '0;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_cmd) begin
						state_q <= S_VOL;
					end
				end
				S_VOL: begin
					limb_q <= '0;
					step_q <= '0;
					state_q <= status.degen ? S_OUT : S_VMUL;
				end
				S_VMUL: begin
					limb_q <= limb_q + 2'd1;
					if (limb_q == 2'(ti_pkg::LIMBS - 1)) begin
						step_q <= step_q + 2'd1;
						if (step_q == 2'd1) begin
							state_q <= S_VSAVE;
						end
					end
				end
				S_VSAVE: begin
					corner_q <= '0;
					state_q <= S_TINIT;
				end
				S_TINIT: begin
					limb_q <= '0;
					step_q <= '0;
					state_q <= S_TMUL;
				end
				S_TMUL: begin
					limb_q <= limb_q + 2'd1;
					if (limb_q == 2'(ti_pkg::LIMBS - 1)) begin
						step_q <= step_q + 2'd1;
						if (step_q == 2'd2) begin
							state_q <= S_TACC;
						end
					end
				end
				S_TACC: begin
					corner_q <= corner_q + 3'd1;
					state_q <= (corner_q == 3'd7) ? S_DINIT : S_TINIT;
				end
				S_DINIT: begin
					bit_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == ti_pkg::BIT_W'(ti_pkg::ACC_W - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TI_ASSERT_NEXT(a_compute_starts, clk, arst_n, in_valid && in_ready && in_cmd, state_q == S_VOL)
	`TI_ASSERT(a_out_slot_free, clk, arst_n, (cmd.op == ti_pkg::OP_OUT) |-> out_free)
	`TI_ASSERT(a_div_count, clk, arst_n, (state_q == S_DIV) |-> (bit_q < ti_pkg::BIT_W'(ti_pkg::ACC_W)))
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for trilinear_interpolator: stream stimulus, random stalls
// and an exact wide-integer model of the interpolation. Depends on ti_pkg and the RTL.
`default_nettype none
module tb;
	localparam int  LIMIT_CYCLES = 3000000;
	localparam bit  CMD_LOAD     = 1'b0;
	localparam bit  CMD_COMPUTE  = 1'b1;

	typedef struct {
		bit             cmd;
		ti_pkg::in_t    f;
		bit             typed;
		logic [31:0]    t_val;
		logic           t_deg;
		logic           t_sat;
	} item_t;

	typedef struct {
		bit          cmd;
		logic [2:0]  idx;
		logic [31:0] val;
		logic [31:0] c[9];
		bit          typed;
		logic [31:0] t_val;
		logic        t_deg;
		logic        t_sat;
	} row_t;

	typedef struct {
		logic [31:0] val;
		logic        deg;
		logic        sat;
	} interp_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [327:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	item_t        stim_q[$];
	interp_t      interp_q[$];
	row_t         rows[20];
	logic [31:0]  corner_mem[8];
	int           errors = 0;
	int           cycles = 0;
	int           sent = 0;
	int           n_loads = 0;
	int           n_results = 0;
	int           n_degen = 0;
	int           n_sat = 0;

	trilinear_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
	endtask

	function automatic interp_t interpolate(input ti_pkg::in_t f);
		logic signed [159:0] xl, xh, xp, yl, yh, yp, zl, zh, zp;
		logic signed [159:0] d1, d2, d3, cv, num, vol;
		logic [159:0] an, av, q, lim;
		logic neg;
		interp_t r;
		xl = $signed(f.x_low); xh = $signed(f.x_high); xp = $signed(f.x_point);
		yl = $signed(f.y_low); yh = $signed(f.y_high); yp = $signed(f.y_point);
		zl = $signed(f.z_low); zh = $signed(f.z_high); zp = $signed(f.z_point);
		r = '{val: 32'd0, deg: 1'b1, sat: 1'b0};
		if (xh == xl || yh == yl || zh == zl)
			return r;
		vol = (xh - xl) * (yh - yl) * (zh - zl);
		num = '0;
		for (int c = 0; c < 8; c++) begin
			d1 = (c & 2) ? xp - xl : xh - xp;
			d2 = (c & 1) ? yp - yl : yh - yp;
			d3 = (c & 4) ? zh - zp : zp - zl;
			cv = $signed(corner_mem[c]);
			num = num + cv * d1 * d2 * d3;
		end
		neg = num[159] ^ vol[159];
		an = num[159] ? -num : num;
		av = vol[159] ? -vol : vol;
		q = an / av;
		lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
		r.deg = 1'b0;
		if (q > lim) begin
			q = lim;
			r.sat = 1'b1;
		end
		r.val = neg ? 32'd0 - q[31:0] : q[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic ti_pkg::in_t noise();
		ti_pkg::in_t f;
		f = '0;
		f.corner_index = 3'($urandom_range(7));
		f.corner_value = rnd32();
		f.x_low = rnd32(); f.x_high = rnd32(); f.x_point = rnd32();
		f.y_low = rnd32(); f.y_high = rnd32(); f.y_point = rnd32();
		f.z_low = rnd32(); f.z_high = rnd32(); f.z_point = rnd32();
		return f;
	endfunction

	task automatic add_load(input logic [2:0] idx, input logic [31:0] v);
		item_t it;
		it = '{cmd: CMD_LOAD, f: noise(), typed: 1'b0, t_val: '0, t_deg: 1'b0, t_sat: 1'b0};
		it.f.corner_index = idx;
		it.f.corner_value = v;
		stim_q.push_back(it);
	endtask

	task automatic add_compute(input logic [31:0] c[9], input bit typed,
			input logic [31:0] tv, input logic td, input logic ts);
		item_t it;
		it = '{cmd: CMD_COMPUTE, f: noise(), typed: typed, t_val: tv, t_deg: td, t_sat: ts};
		{it.f.x_low, it.f.x_high, it.f.x_point} = {c[0], c[1], c[2]};
		{it.f.y_low, it.f.y_high, it.f.y_point} = {c[3], c[4], c[5]};
		{it.f.z_low, it.f.z_high, it.f.z_point} = {c[6], c[7], c[8]};
		stim_q.push_back(it);
	endtask

	// Mostly a well-formed cell axis: small signed span, point inside or near it.
	function automatic void cell_axis(output logic [31:0] lo, hi, pt);
		int s;
		lo = ($urandom_range(3) == 0) ? rnd32() : $urandom_range(32'h0008_0000) - 32'h0004_0000;
		s = (int'($urandom_range(32'h0004_0000)) + 1) * ($urandom_range(4) == 0 ? -1 : 1);
		if ($urandom_range(30) == 0)
			s = 0;
		else if ($urandom_range(15) == 0)
			s = $urandom;
		hi = lo + s;
		pt = ($urandom_range(9) == 0) ? rnd32() : lo + $urandom_range(32'h0004_0000);
	endfunction

	task automatic build_stimulus();
		logic [31:0] c[9];
		// Directed rows: corner loads, degenerate cells on each axis, the unit cell at a
		// corner, at the center and outside, a reversed cell, and full-range spans with
		// far points that saturate both ways.
		rows = '{
			'{CMD_LOAD, 3'd0, 32'h7FFF_FFFF, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd1, 32'h8000_0000, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd2, 32'h0001_0000, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd3, 32'hFFFF_FFFF, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd4, 32'h0000_0000, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd5, 32'h0002_8000, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd6, 32'hFFFE_0000, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd7, 32'h0000_0001, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{32'h10000, 32'h10000, 32'h0, 0, 32'h10000, 0, 0, 32'h10000, 0},
				1'b1, 32'h0, 1'b1, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 32'h10000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h10000, 0},
				1'b1, 32'h0, 1'b1, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 32'h10000, 0, 0, 32'h10000, 0, 32'h8000_0000, 32'h8000_0000, 5},
				1'b1, 32'h0, 1'b1, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000, 0},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 32'h10000, 32'h8000, 0, 32'h10000, 32'h8000, 0, 32'h10000, 32'h8000},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 32'h10000, 32'h30000, 0, 32'h10000, 32'hFFFE_0000, 0, 32'h10000,
					32'h50000},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{32'h10000, 0, 32'h4000, 32'h20000, 0, 32'h1000, 32'h10000, 0, 32'hC000},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 1, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 0, 1, 32'h7FFF_FFFF},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 0, 1, 32'h7FFF_FFFF},
				1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_LOAD, 3'd7, 32'h8000_0000, '{default: 32'h0}, 1'b0, 32'h0, 1'b0, 1'b0},
			'{CMD_COMPUTE, 3'd0, 32'h0,
				'{0, 1, 1, 0, 1, 0, 0, 1, 0},
				1'b0, 32'h0, 1'b0, 1'b0}
		};
		foreach (rows[i]) begin
			if (rows[i].cmd == CMD_LOAD)
				add_load(rows[i].idx, rows[i].val);
			else
				add_compute(rows[i].c, rows[i].typed, rows[i].t_val, rows[i].t_deg,
					rows[i].t_sat);
		end
		// Random part: mostly loads and well-formed cells, some full-range noise.
		while (stim_q.size() < 1350) begin
			if ($urandom_range(9) < 4) begin
				add_load(3'($urandom_range(7)), rnd32());
			end else begin
				if ($urandom_range(7) == 0) begin
					for (int i = 0; i < 9; i++)
						c[i] = rnd32();
				end else begin
					cell_axis(c[0], c[1], c[2]);
					cell_axis(c[3], c[4], c[5]);
					cell_axis(c[6], c[7], c[8]);
				end
				add_compute(c, 1'b0, 32'h0, 1'b0, 1'b0);
			end
		end
	endtask

	function automatic bit quiet();
		return sent >= 700 && sent < 1000;
	endfunction

	// Sender.
	initial begin
		item_t cur;
		interp_t want;
		bit acc;
		build_stimulus();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim_q.size() > 0) begin
			cur = stim_q.pop_front();
			while (!quiet() && $urandom_range(99) < 8) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= cur.f;
			s_axis_tuser <= cur.cmd;
			do begin
				@(negedge clk);
				acc = s_axis_tready;
				@(posedge clk);
			end while (!acc);
			sent++;
			if (cur.cmd == CMD_LOAD) begin
				corner_mem[cur.f.corner_index] = cur.f.corner_value;
				n_loads++;
			end else begin
				want = interpolate(cur.f);
				if (cur.typed)
					want = '{val: cur.t_val, deg: cur.t_deg, sat: cur.t_sat};
				interp_q.push_back(want);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (interp_q.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d transfers (%0d corner loads); checked %0d results,", sent, n_loads,
			n_results);
		$display("%0d of them on degenerate cells and %0d saturated.", n_degen, n_sat);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Receiver, with one long hold-off while the sender keeps offering.
	initial begin
		bit held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= 300) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				for (int i = 0; i < 3000; i++)
					@(posedge clk);
			end
			m_axis_tready <= quiet() || $urandom_range(99) >= 8;
		end
	end

	// Result checker.
	always @(negedge clk) begin
		interp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (interp_q.size() == 0) begin
				report("unexpected result", m_axis_tdata, 32'h0);
			end else begin
				want = interp_q.pop_front();
				if (want.deg)
					n_degen++;
				if (want.sat)
					n_sat++;
				if (m_axis_tdata !== want.val)
					report("interpolated", m_axis_tdata, want.val);
				if (m_axis_tuser[0] !== want.deg)
					report("degenerate", {31'd0, m_axis_tuser[0]}, {31'd0, want.deg});
				if (m_axis_tuser[1] !== want.sat)
					report("saturated", {31'd0, m_axis_tuser[1]}, {31'd0, want.sat});
			end
		end
	end
endmodule
`default_nettype wire
